// File: sv/msbc_pkg.sv
package msbc_pkg;

  // Frame positions while hunting and checking the header
  localparam logic [7:0] POS_HUNT = 8'd0;
  localparam logic [7:0] POS_SEQ  = 8'd1;
  localparam logic [7:0] POS_AD   = 8'd2;
  localparam logic [7:0] POS_Z1   = 8'd3;
  localparam logic [7:0] POS_Z2   = 8'd4;
  localparam logic [7:0] POS_BODY = 8'd5;

  // Header byte values
  localparam logic [7:0] BYTE_SYNC = 8'h01;
  localparam logic [7:0] BYTE_SEQ0 = 8'h08;
  localparam logic [7:0] BYTE_SEQ1 = 8'h38;
  localparam logic [7:0] BYTE_SEQ2 = 8'hC8;
  localparam logic [7:0] BYTE_SEQ3 = 8'hF8;
  localparam logic [7:0] BYTE_AD   = 8'hAD;
  localparam logic [7:0] BYTE_ZERO = 8'h00;

  // Frame length register
  localparam logic [7:0] FRAME_LEN_RESET = 8'd60;
  localparam logic [7:0] FRAME_LEN_MIN   = 8'd7;

  // How many results one byte causes
  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_ONE,
    EMIT_HEAD
  } msbc_emit_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic [1:0] seq_index;
    logic       frame_first;
    logic       frame_last;
  } msbc_res_t;

  typedef struct packed {
    msbc_emit_t kind;
    msbc_res_t  res;
  } msbc_emit_bus_t;

endpackage

// File: sv/msbc_in_if.sv
interface msbc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

// File: sv/msbc_out_if.sv
interface msbc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic [1:0] seq_index;
  logic       frame_first;
  logic       frame_last;

  modport source (output valid, output payload_byte, output seq_index,
                  output frame_first, output frame_last, input ready);
  modport sink (input valid, input payload_byte, input seq_index,
                input frame_first, input frame_last, output ready);
endinterface

// File: sv/msbc_hdr_fsm.sv
module msbc_hdr_fsm (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    step,
  input  logic [7:0]              byte_i,
  input  logic [7:0]              trailer,
  output msbc_pkg::msbc_emit_bus_t emit
);

  logic [7:0] pos_r, pos_nxt;
  logic [1:0] seq_r, seq_nxt;

  // Decode the byte against the current frame position
  always_comb begin
    pos_nxt                = pos_r;
    seq_nxt                = seq_r;
    emit.kind              = msbc_pkg::EMIT_NONE;
    emit.res.payload_byte  = byte_i;
    emit.res.seq_index     = seq_r;
    emit.res.frame_first   = 1'b0;
    emit.res.frame_last    = 1'b0;
    unique case (pos_r)
      msbc_pkg::POS_HUNT: begin
        if (byte_i == msbc_pkg::BYTE_SYNC) pos_nxt = msbc_pkg::POS_SEQ;
      end
      msbc_pkg::POS_SEQ: begin
        pos_nxt = msbc_pkg::POS_AD;
        case (byte_i)
          msbc_pkg::BYTE_SEQ0: seq_nxt = 2'd0;
          msbc_pkg::BYTE_SEQ1: seq_nxt = 2'd1;
          msbc_pkg::BYTE_SEQ2: seq_nxt = 2'd2;
          msbc_pkg::BYTE_SEQ3: seq_nxt = 2'd3;
          default:             pos_nxt = msbc_pkg::POS_HUNT;
        endcase
      end
      msbc_pkg::POS_AD: begin
        pos_nxt = (byte_i == msbc_pkg::BYTE_AD) ? msbc_pkg::POS_Z1 : msbc_pkg::POS_HUNT;
      end
      msbc_pkg::POS_Z1: begin
        pos_nxt = (byte_i == msbc_pkg::BYTE_ZERO) ? msbc_pkg::POS_Z2 : msbc_pkg::POS_HUNT;
      end
      msbc_pkg::POS_Z2: begin
        if (byte_i == msbc_pkg::BYTE_ZERO) begin
          emit.kind             = msbc_pkg::EMIT_HEAD;
          emit.res.payload_byte = msbc_pkg::BYTE_AD;
          emit.res.frame_first  = 1'b1;
          pos_nxt               = msbc_pkg::POS_BODY;
        end else begin
          pos_nxt = msbc_pkg::POS_HUNT;
        end
      end
      default: begin
        // Swallow the trailer, or pass a payload byte through
        if (pos_r >= trailer) begin
          pos_nxt = msbc_pkg::POS_HUNT;
        end else begin
          emit.kind           = msbc_pkg::EMIT_ONE;
          emit.res.frame_last = (pos_r == trailer - 8'd1);
          pos_nxt             = pos_r + 8'd1;
        end
      end
    endcase
  end

  // Advance the position once per consumed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= msbc_pkg::POS_HUNT;
      seq_r <= 2'd0;
    end else if (step) begin
      pos_r <= pos_nxt;
      seq_r <= seq_nxt;
    end
  end

endmodule

// File: sv/msbc_out_stage.sv
module msbc_out_stage (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     load,
  input  msbc_pkg::msbc_emit_bus_t emit,
  input  logic                     out_ready,
  output logic                     out_valid,
  output msbc_pkg::msbc_res_t      res,
  output logic                     can_load
);

  logic                valid_r, valid_nxt;
  msbc_pkg::msbc_res_t res_r, res_nxt;
  logic [1:0]          rem_r, rem_nxt;

  // Free when empty or once the last result of a burst is taken
  assign can_load  = !valid_r || (out_ready && (rem_r == 2'd0));
  assign out_valid = valid_r;
  assign res       = res_r;

  // Load a new result or step through the two zero bytes of a header burst
  always_comb begin
    valid_nxt = valid_r;
    res_nxt   = res_r;
    rem_nxt   = rem_r;
    if (load) begin
      valid_nxt = 1'b1;
      res_nxt   = emit.res;
      rem_nxt   = (emit.kind == msbc_pkg::EMIT_HEAD) ? 2'd2 : 2'd0;
    end else if (valid_r && out_ready) begin
      if (rem_r != 2'd0) begin
        res_nxt.payload_byte = msbc_pkg::BYTE_ZERO;
        res_nxt.frame_first  = 1'b0;
        res_nxt.frame_last   = 1'b0;
        rem_nxt              = rem_r - 2'd1;
      end else begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      rem_r   <= 2'd0;
    end else begin
      valid_r <= valid_nxt;
      rem_r   <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

endmodule

// File: sv/msbc_h2_frame_deframer.sv
// mSBC H2 frame deframer.
// in_ch carries one received byte per item; out_ch carries payload items
// (payload_byte, seq_index, frame_first, frame_last). cfg_we/cfg_wdata write
// frame_length (total frame bytes, values below 7 act as 7); write it only
// while the block is idle.
// The block hunts for 0x01, a sequence byte (08/38/C8/F8 -> 0..3) and
// 0xAD 0x00 0x00. On the second 0x00 it emits 0xAD (frame_first), 0x00, 0x00,
// then passes each payload byte and marks the byte before the trailer as
// frame_last. The trailer and all header bytes give no item.
// An accepted byte lands in an input register and its first result is
// registered in the output register before it is offered on out_ch.
// Throughput: one byte per cycle while out_ch is ready; the header burst
// holds the output register until the burst counter has sent all three items.
// When out_ch stalls, one more byte is taken into the input register and
// bytes that cause no result still drain; in_ch.ready drops once the input
// register holds a byte that needs the busy output register.
// Reset (rst_n low, synchronous) empties both registers, returns to the hunt
// and sets frame_length to 60.
module msbc_h2_frame_deframer (
  input  logic             clk,
  input  logic             rst_n,
  msbc_in_if.sink          in_ch,
  msbc_out_if.source       out_ch,
  input  logic             cfg_we,
  input  logic [7:0]       cfg_wdata
);

  logic                     in_valid_r;
  logic [7:0]               in_byte_r;
  logic [7:0]               frame_len_r;
  logic [7:0]               len_eff;
  logic [7:0]               trailer;
  logic                     step;
  logic                     can_load;
  logic                     load;
  msbc_pkg::msbc_emit_bus_t emit;
  msbc_pkg::msbc_res_t      res;

  // Frame length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_len_r <= msbc_pkg::FRAME_LEN_RESET;
    end else if (cfg_we) begin
      frame_len_r <= cfg_wdata;
    end
  end

  assign len_eff = (frame_len_r < msbc_pkg::FRAME_LEN_MIN) ? msbc_pkg::FRAME_LEN_MIN
                                                           : frame_len_r;
  assign trailer = len_eff - 8'd1;

  // Consume the held byte when it gives no result or the output is free
  assign step        = in_valid_r && ((emit.kind == msbc_pkg::EMIT_NONE) || can_load);
  assign load        = step && (emit.kind != msbc_pkg::EMIT_NONE);
  assign in_ch.ready = !in_valid_r || step;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_valid_r <= 1'b1;
    end else if (step) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) in_byte_r <= in_ch.in_byte;
  end

  msbc_hdr_fsm u_fsm (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .byte_i  (in_byte_r),
    .trailer (trailer),
    .emit    (emit)
  );

  msbc_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .emit      (emit),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .res       (res),
    .can_load  (can_load)
  );

  assign out_ch.payload_byte = res.payload_byte;
  assign out_ch.seq_index    = res.seq_index;
  assign out_ch.frame_first  = res.frame_first;
  assign out_ch.frame_last   = res.frame_last;

`ifndef ASSERT_OFF
  // The first header byte taken is followed by a zero byte
  a_head_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && out_ch.frame_first |=>
      out_ch.valid && (out_ch.payload_byte == msbc_pkg::BYTE_ZERO) && !out_ch.frame_first)
    else $error("header burst broken after first byte");

  // A held byte that is refused stays put
  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !in_ch.ready |=> in_valid_r && $stable(in_byte_r))
    else $error("held input byte lost while stalled");

  // Output valid only rises after a byte was consumed
  a_rise_after_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(step))
    else $error("result appeared without a consumed byte");

  // A result is never both first and last
  a_first_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.frame_first && out_ch.frame_last))
    else $error("result marked first and last");
`endif

endmodule

// File: test/tb_msbc_h2_frame_deframer.sv
module tb_msbc_h2_frame_deframer;
  timeunit 1ns;
  timeprecision 1ps;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  msbc_in_if  in_ch ();
  msbc_out_if out_ch ();

  msbc_h2_frame_deframer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Bytes waiting to be sent and payload items still owed by the block
  logic [7:0]          byte_queue[$];
  msbc_pkg::msbc_res_t payload_expected[$];

  // Deframer state as the checker sees it
  logic [7:0] frame_len;
  logic [7:0] frame_pos;
  logic [1:0] frame_seq;

  int unsigned failures;
  bit          steady;

  always #2 clk = ~clk;

  function automatic void push_expected(input logic [7:0] b, input logic first,
                                        input logic last);
    msbc_pkg::msbc_res_t r;
    r.payload_byte = b;
    r.seq_index    = frame_seq;
    r.frame_first  = first;
    r.frame_last   = last;
    payload_expected.push_back(r);
  endfunction

  // Advance the frame position by one received byte
  function automatic void predict_byte(input logic [7:0] b);
    logic [7:0] eff_len;
    logic [7:0] trailer_pos;
    eff_len     = (frame_len < msbc_pkg::FRAME_LEN_MIN) ? msbc_pkg::FRAME_LEN_MIN
                                                        : frame_len;
    trailer_pos = eff_len - 8'd1;
    case (frame_pos)
      msbc_pkg::POS_HUNT: begin
        if (b == msbc_pkg::BYTE_SYNC) frame_pos = msbc_pkg::POS_SEQ;
      end
      msbc_pkg::POS_SEQ: begin
        frame_pos = msbc_pkg::POS_AD;
        case (b)
          msbc_pkg::BYTE_SEQ0: frame_seq = 2'd0;
          msbc_pkg::BYTE_SEQ1: frame_seq = 2'd1;
          msbc_pkg::BYTE_SEQ2: frame_seq = 2'd2;
          msbc_pkg::BYTE_SEQ3: frame_seq = 2'd3;
          default:             frame_pos = msbc_pkg::POS_HUNT;
        endcase
      end
      msbc_pkg::POS_AD: begin
        frame_pos = (b == msbc_pkg::BYTE_AD) ? msbc_pkg::POS_Z1 : msbc_pkg::POS_HUNT;
      end
      msbc_pkg::POS_Z1: begin
        frame_pos = (b == msbc_pkg::BYTE_ZERO) ? msbc_pkg::POS_Z2 : msbc_pkg::POS_HUNT;
      end
      msbc_pkg::POS_Z2: begin
        if (b != msbc_pkg::BYTE_ZERO) begin
          frame_pos = msbc_pkg::POS_HUNT;
        end else begin
          push_expected(msbc_pkg::BYTE_AD, 1'b1, 1'b0);
          push_expected(msbc_pkg::BYTE_ZERO, 1'b0, 1'b0);
          push_expected(msbc_pkg::BYTE_ZERO, 1'b0, 1'b0);
          frame_pos = msbc_pkg::POS_BODY;
        end
      end
      default: begin
        // a shrunken length can leave the position past the trailer
        if (frame_pos >= trailer_pos) begin
          frame_pos = msbc_pkg::POS_HUNT;
        end else begin
          push_expected(b, 1'b0, frame_pos == trailer_pos - 8'd1);
          frame_pos = frame_pos + 8'd1;
        end
      end
    endcase
  endfunction

  function automatic logic [7:0] seq_byte(input logic [1:0] s);
    case (s)
      2'd0:    return msbc_pkg::BYTE_SEQ0;
      2'd1:    return msbc_pkg::BYTE_SEQ1;
      2'd2:    return msbc_pkg::BYTE_SEQ2;
      default: return msbc_pkg::BYTE_SEQ3;
    endcase
  endfunction

  function automatic bit header_fits(input int unsigned pos, input logic [7:0] b);
    case (pos)
      1:       return b == msbc_pkg::BYTE_SEQ0 || b == msbc_pkg::BYTE_SEQ1 ||
                      b == msbc_pkg::BYTE_SEQ2 || b == msbc_pkg::BYTE_SEQ3;
      2:       return b == msbc_pkg::BYTE_AD;
      default: return b == msbc_pkg::BYTE_ZERO;
    endcase
  endfunction

  // Queue a well-formed frame with random sequence, payload and trailer
  task automatic queue_frame(input logic [7:0] len);
    int unsigned eff_len;
    eff_len = (len < msbc_pkg::FRAME_LEN_MIN) ? msbc_pkg::FRAME_LEN_MIN : len;
    byte_queue.push_back(msbc_pkg::BYTE_SYNC);
    byte_queue.push_back(seq_byte(2'($urandom_range(0, 3))));
    byte_queue.push_back(msbc_pkg::BYTE_AD);
    byte_queue.push_back(msbc_pkg::BYTE_ZERO);
    byte_queue.push_back(msbc_pkg::BYTE_ZERO);
    for (int unsigned i = 5; i < eff_len; i++)
      byte_queue.push_back(8'($urandom_range(0, 255)));
  endtask

  // Queue a header that breaks off with a wrong byte at a random position
  task automatic queue_broken_header();
    int unsigned bad_pos;
    logic [7:0]  bad;
    bad_pos = $urandom_range(1, 4);
    bad     = 8'($urandom_range(0, 255));
    byte_queue.push_back(msbc_pkg::BYTE_SYNC);
    if (bad_pos > 1) byte_queue.push_back(seq_byte(2'($urandom_range(0, 3))));
    if (bad_pos > 2) byte_queue.push_back(msbc_pkg::BYTE_AD);
    if (bad_pos > 3) byte_queue.push_back(msbc_pkg::BYTE_ZERO);
    while (header_fits(bad_pos, bad)) bad = 8'($urandom_range(0, 255));
    byte_queue.push_back(bad);
  endtask

  task automatic queue_noise();
    int unsigned n;
    n = $urandom_range(1, 4);
    repeat (n) byte_queue.push_back(8'($urandom_range(0, 255)));
  endtask

  // Hold until every byte is sent and every payload item has come back
  task automatic wait_drained();
    @(negedge clk);
    while (byte_queue.size() != 0 || in_ch.valid || payload_expected.size() != 0)
      @(negedge clk);
  endtask

  task automatic set_frame_length(input logic [7:0] len);
    wait_drained();
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= len;
    frame_len  = len;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Byte driver: predict on acceptance, then offer the next byte or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid   <= 1'b0;
      in_ch.in_byte <= 8'h00;
    end else begin
      if (in_ch.valid && in_ch.ready) predict_byte(in_ch.in_byte);
      if (!in_ch.valid || in_ch.ready) begin
        if (byte_queue.size() != 0 && (steady || $urandom_range(0, 99) >= 15)) begin
          in_ch.valid   <= 1'b1;
          in_ch.in_byte <= byte_queue.pop_front();
        end else begin
          in_ch.valid   <= 1'b0;
        end
      end
    end
  end

  // Payload monitor: check each item against the oldest expectation
  always @(posedge clk) begin
    msbc_pkg::msbc_res_t exp_item;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (payload_expected.size() == 0) begin
          $error("unexpected payload item %h", out_ch.payload_byte);
          failures++;
        end else begin
          exp_item = payload_expected.pop_front();
          if (out_ch.payload_byte !== exp_item.payload_byte) begin
            $error("payload_byte expected %h got %h", exp_item.payload_byte,
                   out_ch.payload_byte);
            failures++;
          end
          if (out_ch.seq_index !== exp_item.seq_index) begin
            $error("seq_index expected %0d got %0d", exp_item.seq_index,
                   out_ch.seq_index);
            failures++;
          end
          if (out_ch.frame_first !== exp_item.frame_first) begin
            $error("frame_first expected %b got %b", exp_item.frame_first,
                   out_ch.frame_first);
            failures++;
          end
          if (out_ch.frame_last !== exp_item.frame_last) begin
            $error("frame_last expected %b got %b", exp_item.frame_last,
                   out_ch.frame_last);
            failures++;
          end
        end
      end
      out_ch.ready <= steady || ($urandom_range(0, 99) >= 15);
    end
  end

  initial begin
    #1_000_000;
    $display("tb_msbc_h2_frame_deframer failed");
    $finish;
  end

  initial begin
    int unsigned phase;
    int unsigned pick;
    logic [7:0]  new_len;

    clk           = 1'b0;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = 8'h00;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = 8'h00;
    out_ch.ready  = 1'b0;
    frame_len     = msbc_pkg::FRAME_LEN_RESET;
    frame_pos     = msbc_pkg::POS_HUNT;
    frame_seq     = 2'd0;
    failures      = 0;
    steady        = 1'b0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Broken headers: a second sync byte is dropped, not taken as a new start
    byte_queue.push_back(msbc_pkg::BYTE_SYNC);
    byte_queue.push_back(msbc_pkg::BYTE_SYNC);
    byte_queue.push_back(msbc_pkg::BYTE_SEQ0);
    byte_queue.push_back(msbc_pkg::BYTE_SYNC);
    byte_queue.push_back(msbc_pkg::BYTE_SEQ0);
    byte_queue.push_back(8'hAC);
    byte_queue.push_back(msbc_pkg::BYTE_SYNC);
    byte_queue.push_back(msbc_pkg::BYTE_SEQ1);
    byte_queue.push_back(msbc_pkg::BYTE_AD);
    byte_queue.push_back(msbc_pkg::BYTE_SYNC);
    byte_queue.push_back(msbc_pkg::BYTE_SYNC);
    byte_queue.push_back(msbc_pkg::BYTE_SEQ2);
    byte_queue.push_back(msbc_pkg::BYTE_AD);
    byte_queue.push_back(msbc_pkg::BYTE_ZERO);
    byte_queue.push_back(8'hFF);
    // One frame at the length left by reset
    queue_frame(msbc_pkg::FRAME_LEN_RESET);

    // Shortest frame: the single body byte is also the last one
    set_frame_length(msbc_pkg::FRAME_LEN_MIN);
    byte_queue.push_back(msbc_pkg::BYTE_SYNC);
    byte_queue.push_back(msbc_pkg::BYTE_SEQ3);
    byte_queue.push_back(msbc_pkg::BYTE_AD);
    byte_queue.push_back(msbc_pkg::BYTE_ZERO);
    byte_queue.push_back(msbc_pkg::BYTE_ZERO);
    byte_queue.push_back(8'hFF);
    byte_queue.push_back(8'h5A);

    // Random phases, mostly whole frames at small lengths
    phase = 0;
    while (phase < 3) begin
      if (phase == 0) new_len = 8'd0;
      else if ($urandom_range(0, 99) < 15) new_len = 8'($urandom_range(1, 6));
      else new_len = 8'($urandom_range(7, 16));
      set_frame_length(new_len);
      steady = (phase == 2);
      while (byte_queue.size() < 16) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) queue_frame(new_len);
        else if (pick < 85) queue_broken_header();
        else queue_noise();
      end
      phase++;
    end
    steady = 1'b0;

    // Longest length, with the frame cut short by a smaller length mid-payload
    set_frame_length(8'd255);
    byte_queue.push_back(msbc_pkg::BYTE_SYNC);
    byte_queue.push_back(msbc_pkg::BYTE_SEQ1);
    byte_queue.push_back(msbc_pkg::BYTE_AD);
    byte_queue.push_back(msbc_pkg::BYTE_ZERO);
    byte_queue.push_back(msbc_pkg::BYTE_ZERO);
    repeat (10) byte_queue.push_back(8'($urandom_range(0, 255)));
    set_frame_length(8'd12);
    byte_queue.push_back(8'($urandom_range(0, 255)));
    queue_frame(8'd12);

    wait_drained();
    repeat (20) @(posedge clk);
    if (payload_expected.size() != 0) begin
      $error("%0d payload items never arrived", payload_expected.size());
      failures++;
    end
    if (failures == 0) begin
      $display("tb_msbc_h2_frame_deframer passed");
    end else begin
      $display("tb_msbc_h2_frame_deframer failed");
    end
    $finish;
  end

endmodule
